/* src/assert_macros.svh */
// Assertion helpers shared by the RTL.
// Each check is clocked on the rising edge and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tarpu_pkg.sv */
`timescale 1ns / 1ps

package tarpu_pkg;

    // Table size default
    localparam int TABLE_DEPTH_DEFAULT = 64;

    // Field widths
    localparam int KIND_W    = 3;
    localparam int ID_W      = 8;
    localparam int POS_W     = 16;
    localparam int MT_W      = 16;
    localparam int TIME_W    = 32;
    localparam int SETTLE_W  = 10;
    localparam int STATUS_W  = 3;
    localparam int EIDX_W    = 6;
    localparam int SCOUNT_W  = 7;
    localparam int ACT_W     = ID_W + POS_W + MT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;

    localparam logic [ID_W-1:0]     RESET_ID_INIT = 8'd254;
    localparam logic [SETTLE_W-1:0] SETTLE_INIT   = 10'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_ACTION_ID = 4'd0,
        CFG_SETTLE_MS       = 4'd1
    } t_cfg_reg;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_START  = 3'd1,
        KIND_STOP   = 3'd2,
        KIND_RECORD = 3'd3,
        KIND_PLAY   = 3'd4,
        KIND_CLEAR  = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_FULL          = 3'd1,
        ST_BUSY_PLAYING  = 3'd2,
        ST_ALREADY_REC   = 3'd3,
        ST_NOT_REC       = 3'd4,
        ST_BUSY_REC      = 3'd5,
        ST_ALREADY_PLAY  = 3'd6,
        ST_EMPTY         = 3'd7
    } t_status;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   servo_id;
        logic [POS_W-1:0]  target_position;
        logic [MT_W-1:0]   move_duration;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic                 emit_valid;
        logic                 emit_is_reset;
        logic [ID_W-1:0]      emit_servo_id;
        logic [POS_W-1:0]     emit_position;
        logic [MT_W-1:0]      emit_move_time;
        logic [EIDX_W-1:0]    emit_index;
        logic [TIME_W-1:0]    move_end_time;
        logic                 recording_now;
        logic                 playing_now;
        logic [SCOUNT_W-1:0]  stored_count;
        logic                 play_done;
    } t_rsp;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Controller to datapath commands
    typedef struct packed {
        logic fetch;   // latch request, start table reads
        logic commit;  // apply request, load result register
    } t_cmd;

endpackage

/* src/tarpu_req_if.sv */
`timescale 1ns / 1ps

interface tarpu_req_if;
    logic                             valid;
    logic                             ready;
    logic [tarpu_pkg::KIND_W-1:0]     kind;
    logic [tarpu_pkg::ID_W-1:0]       servo_id;
    logic [tarpu_pkg::POS_W-1:0]      target_position;
    logic [tarpu_pkg::MT_W-1:0]       move_duration;

    modport source (
        output valid, kind, servo_id, target_position, move_duration,
        input  ready
    );
    modport sink (
        input  valid, kind, servo_id, target_position, move_duration,
        output ready
    );
endinterface

/* src/tarpu_rsp_if.sv */
`timescale 1ns / 1ps

interface tarpu_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [tarpu_pkg::STATUS_W-1:0]     status;
    logic                               emit_valid;
    logic                               emit_is_reset;
    logic [tarpu_pkg::ID_W-1:0]         emit_servo_id;
    logic [tarpu_pkg::POS_W-1:0]        emit_position;
    logic [tarpu_pkg::MT_W-1:0]         emit_move_time;
    logic [tarpu_pkg::EIDX_W-1:0]       emit_index;
    logic [tarpu_pkg::TIME_W-1:0]       move_end_time;
    logic                               recording_now;
    logic                               playing_now;
    logic [tarpu_pkg::SCOUNT_W-1:0]     stored_count;
    logic                               play_done;

    modport source (
        output valid, status, emit_valid, emit_is_reset, emit_servo_id, emit_position,
               emit_move_time, emit_index, move_end_time, recording_now, playing_now,
               stored_count, play_done,
        input  ready
    );
    modport sink (
        input  valid, status, emit_valid, emit_is_reset, emit_servo_id, emit_position,
               emit_move_time, emit_index, move_end_time, recording_now, playing_now,
               stored_count, play_done,
        output ready
    );
endinterface

/* src/tarpu_cfg_if.sv */
`timescale 1ns / 1ps

interface tarpu_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tarpu_pkg::CFG_IDX_W-1:0]    index;
    logic [tarpu_pkg::CFG_DATA_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* src/tarpu_ctrl.sv */
`timescale 1ns / 1ps

module tarpu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  logic            i_rsp_ready,
    output logic            o_rsp_valid,
    output tarpu_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;
    logic   w_slot_free;

    // Result register is free when empty or drained this cycle
    assign w_slot_free  = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready  = (r_state == S_IDLE);
    assign o_cmd.fetch  = (r_state == S_IDLE) && i_req_valid;
    assign o_cmd.commit = (r_state == S_EXEC) && w_slot_free;
    assign o_rsp_valid  = r_rsp_valid;

    // Step through fetch and execute
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold result valid until taken
    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (o_cmd.commit) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

/* src/tarpu_dp.sv */
`timescale 1ns / 1ps

module tarpu_dp #(
    parameter int TABLE_DEPTH = tarpu_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tarpu_pkg::t_cmd    i_cmd,
    input  tarpu_pkg::t_req    i_req,
    input  tarpu_pkg::t_cfg_wr i_cfg,
    output tarpu_pkg::t_rsp    o_rsp
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int TIME_W = tarpu_pkg::TIME_W;
    localparam int ACT_W  = tarpu_pkg::ACT_W;
    localparam int MT_W   = tarpu_pkg::MT_W;
    localparam int POS_W  = tarpu_pkg::POS_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    // Action and timestamp tables
    logic [ACT_W-1:0]  act_mem   [TABLE_DEPTH];
    logic [TIME_W-1:0] stamp_mem [TABLE_DEPTH];
    logic [ACT_W-1:0]  r_act_rd;
    logic [TIME_W-1:0] r_stamp_rd;
    logic [IDX_W-1:0]  w_act_addr;
    logic [IDX_W-1:0]  w_stamp_addr;
    logic              w_wr_en;

    // Configuration
    logic [tarpu_pkg::ID_W-1:0]     r_reset_id;
    logic [tarpu_pkg::SETTLE_W-1:0] r_settle;

    // Latched request and precomputed sums
    tarpu_pkg::t_req   r_req;
    logic [TIME_W-1:0] r_end_base;
    logic [TIME_W-1:0] r_play_nx;
    logic              w_fetch_tick;

    // Architectural state
    logic [TIME_W-1:0] r_now,       n_now;
    logic [TIME_W-1:0] r_rec_time,  n_rec_time;   // now minus record start
    logic [TIME_W-1:0] r_play_time, n_play_time;  // now minus play start
    logic [TIME_W-1:0] r_due_rel,   n_due_rel;    // next due minus play start
    logic              r_recording, n_recording;
    logic              r_playing,   n_playing;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic [CNT_W-1:0]  r_play_idx,  n_play_idx;

    // Execute-step controls
    logic              w_emit;
    logic              w_done;
    logic [CNT_W-1:0]  w_emit_idx;
    tarpu_pkg::t_status w_status;
    tarpu_pkg::t_rsp   w_rsp;
    tarpu_pkg::t_rsp   r_rsp;

    // Pick read addresses: play starts from the table head
    assign w_fetch_tick = (i_req.kind == tarpu_pkg::KIND_TICK);
    always_comb begin
        if (i_req.kind == tarpu_pkg::KIND_PLAY) begin
            w_act_addr   = '0;
            w_stamp_addr = IDX_W'(1);
        end else begin
            w_act_addr   = r_play_idx[IDX_W-1:0];
            w_stamp_addr = IDX_W'(r_play_idx + CNT_W'(1));
        end
    end

    // Read both tables when a request is taken
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_act_rd   <= act_mem[w_act_addr];
            r_stamp_rd <= stamp_mem[w_stamp_addr];
        end
    end

    // Append a recorded action
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_wr_en) begin
            act_mem[r_count[IDX_W-1:0]]   <= {r_req.servo_id, r_req.target_position,
                                              r_req.move_duration};
            stamp_mem[r_count[IDX_W-1:0]] <= r_rec_time;
        end
    end

    // Latch request and prepare time sums
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_req      <= i_req;
            r_end_base <= r_now + TIME_W'(r_settle) + TIME_W'(w_fetch_tick);
            r_play_nx  <= w_fetch_tick ? (r_play_time + TIME_W'(1)) : '0;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_id <= tarpu_pkg::RESET_ID_INIT;
            r_settle   <= tarpu_pkg::SETTLE_INIT;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == tarpu_pkg::CFG_RESET_ACTION_ID) begin
                r_reset_id <= i_cfg.data[tarpu_pkg::ID_W-1:0];
            end else if (i_cfg.index == tarpu_pkg::CFG_SETTLE_MS) begin
                r_settle <= i_cfg.data[tarpu_pkg::SETTLE_W-1:0];
            end
        end
    end

    // Execute the latched request
    always_comb begin
        n_now       = r_now;
        n_rec_time  = r_rec_time;
        n_play_time = r_play_time;
        n_due_rel   = r_due_rel;
        n_recording = r_recording;
        n_playing   = r_playing;
        n_count     = r_count;
        n_play_idx  = r_play_idx;
        w_wr_en     = 1'b0;
        w_emit      = 1'b0;
        w_done      = 1'b0;
        w_emit_idx  = r_play_idx;
        w_status    = tarpu_pkg::ST_OK;
        w_rsp       = '0;

        case (r_req.kind)
            tarpu_pkg::KIND_TICK: begin
                n_now       = r_now + TIME_W'(1);
                n_rec_time  = r_rec_time + TIME_W'(1);
                n_play_time = r_play_nx;
                if (r_playing) begin
                    if (r_play_idx >= r_count) begin
                        n_playing = 1'b0;
                        w_done    = 1'b1;
                    end else if (r_play_nx >= r_due_rel) begin
                        w_emit = 1'b1;
                    end
                end
            end
            tarpu_pkg::KIND_START: begin
                if (r_playing) begin
                    w_status = tarpu_pkg::ST_BUSY_PLAYING;
                end else if (r_recording) begin
                    w_status = tarpu_pkg::ST_ALREADY_REC;
                end else begin
                    n_count     = '0;
                    n_recording = 1'b1;
                    n_rec_time  = '0;
                end
            end
            tarpu_pkg::KIND_STOP: begin
                if (!r_recording) begin
                    w_status = tarpu_pkg::ST_NOT_REC;
                end else begin
                    n_recording = 1'b0;
                end
            end
            tarpu_pkg::KIND_RECORD: begin
                if (r_count >= DEPTH_C) begin
                    w_status = tarpu_pkg::ST_FULL;
                end else begin
                    w_wr_en = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            tarpu_pkg::KIND_PLAY: begin
                if (r_recording) begin
                    w_status = tarpu_pkg::ST_BUSY_REC;
                end else if (r_playing) begin
                    w_status = tarpu_pkg::ST_ALREADY_PLAY;
                end else if (r_count == '0) begin
                    w_status = tarpu_pkg::ST_EMPTY;
                end else begin
                    n_playing   = 1'b1;
                    n_play_time = '0;
                    n_due_rel   = '0;
                    w_emit_idx  = '0;
                    w_emit      = 1'b1;
                end
            end
            tarpu_pkg::KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase

        // Emit one entry and arm the next due time
        if (w_emit) begin
            n_play_idx = w_emit_idx + CNT_W'(1);
            if (n_play_idx < r_count) begin
                n_due_rel = r_stamp_rd;
            end
            w_rsp.emit_valid     = 1'b1;
            w_rsp.emit_servo_id  = r_act_rd[ACT_W-1 -: tarpu_pkg::ID_W];
            w_rsp.emit_is_reset  = (r_act_rd[ACT_W-1 -: tarpu_pkg::ID_W] == r_reset_id);
            w_rsp.emit_position  = r_act_rd[MT_W +: POS_W];
            w_rsp.emit_move_time = r_act_rd[MT_W-1:0];
            w_rsp.emit_index     = tarpu_pkg::EIDX_W'(w_emit_idx);
            w_rsp.move_end_time  = r_end_base + TIME_W'(r_act_rd[MT_W-1:0]);
        end

        w_rsp.status        = w_status;
        w_rsp.recording_now = n_recording;
        w_rsp.playing_now   = n_playing;
        w_rsp.stored_count  = tarpu_pkg::SCOUNT_W'(n_count);
        w_rsp.play_done     = w_done;
    end

    // Commit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= '0;
            r_rec_time  <= '0;
            r_play_time <= '0;
            r_due_rel   <= '0;
            r_recording <= 1'b0;
            r_playing   <= 1'b0;
            r_count     <= '0;
            r_play_idx  <= '0;
        end else if (i_cmd.commit) begin
            r_now       <= n_now;
            r_rec_time  <= n_rec_time;
            r_play_time <= n_play_time;
            r_due_rel   <= n_due_rel;
            r_recording <= n_recording;
            r_playing   <= n_playing;
            r_count     <= n_count;
            r_play_idx  <= n_play_idx;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

/* src/timed_action_record_playback_unit.sv */
// Timed action recorder and player.
// Channels: i_req takes requests (tick, start record, stop record, record
// action, play, clear) with the action fields; o_rsp returns exactly one
// result per request; i_cfg writes the reset-action id (index 0) and the
// settle margin in ms (index 1), always ready; the user must write it only
// while the unit is idle, which the block itself does not enforce.
// Each request takes two steps: a fetch step reads the action and timestamp
// tables into registers, then an execute step executes and loads the result
// register; a new request is taken only once the previous one has executed.
// Reset clears the ms clock, the modes, the entry count and the result valid;
// table contents are unknown but only entries below the count are read.
// If the receiver stalls, the result holds in the output register; one more
// request is still accepted and waits in its execute step until the result
// register frees.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module timed_action_record_playback_unit #(
    parameter int TABLE_DEPTH = tarpu_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tarpu_req_if.sink    i_req,
    tarpu_cfg_if.sink    i_cfg,
    tarpu_rsp_if.source  o_rsp
);

    tarpu_pkg::t_cmd    w_cmd;
    tarpu_pkg::t_req    w_req;
    tarpu_pkg::t_cfg_wr w_cfg;
    tarpu_pkg::t_rsp    w_rsp;
    logic               w_req_ready;
    logic               w_rsp_valid;

    // Pack channel payloads
    assign w_req.kind            = i_req.kind;
    assign w_req.servo_id        = i_req.servo_id;
    assign w_req.target_position = i_req.target_position;
    assign w_req.move_duration   = i_req.move_duration;

    assign w_cfg.valid = i_cfg.valid;
    assign w_cfg.index = i_cfg.index;
    assign w_cfg.data  = i_cfg.data;
    assign i_cfg.ready = 1'b1;

    tarpu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (w_rsp_valid),
        .o_cmd       (w_cmd)
    );

    tarpu_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (w_req),
        .i_cfg   (w_cfg),
        .o_rsp   (w_rsp)
    );

    // Drive result channel
    assign i_req.ready          = w_req_ready;
    assign o_rsp.valid          = w_rsp_valid;
    assign o_rsp.status         = w_rsp.status;
    assign o_rsp.emit_valid     = w_rsp.emit_valid;
    assign o_rsp.emit_is_reset  = w_rsp.emit_is_reset;
    assign o_rsp.emit_servo_id  = w_rsp.emit_servo_id;
    assign o_rsp.emit_position  = w_rsp.emit_position;
    assign o_rsp.emit_move_time = w_rsp.emit_move_time;
    assign o_rsp.emit_index     = w_rsp.emit_index;
    assign o_rsp.move_end_time  = w_rsp.move_end_time;
    assign o_rsp.recording_now  = w_rsp.recording_now;
    assign o_rsp.playing_now    = w_rsp.playing_now;
    assign o_rsp.stored_count   = w_rsp.stored_count;
    assign o_rsp.play_done      = w_rsp.play_done;

    // One request in flight: no request is taken during its execute step
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready, "request accepted during execute")
    // Never overwrite a result that is still waiting
    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready, !w_cmd.commit, "pending result overwritten")
    // End of playback leaves playing mode and emits nothing
    `ASSERT_IMPL(a_done_stops, i_clk, i_rst_n, o_rsp.valid && o_rsp.play_done, !o_rsp.playing_now && !o_rsp.emit_valid, "playback end inconsistent")
    // Without an emission the entry fields stay zero
    `ASSERT_IMPL(a_quiet_emit, i_clk, i_rst_n, o_rsp.valid && !o_rsp.emit_valid, o_rsp.move_end_time == 32'd0 && o_rsp.emit_servo_id == 8'd0, "entry fields set without emission")

endmodule
